/* hdl/adu_pkg.sv */
// ----------------------------------------------------------------------------
// adu_pkg
// Shared constants, register codes and types of the Adam update block.
// ----------------------------------------------------------------------------
`default_nettype none

package adu_pkg;

  // moment store geometry (a power of two of at most 4096 entries)
  localparam int NUM_ELEMENTS = 4096;
  localparam int ADDR_W       = $clog2(NUM_ELEMENTS);

  // field widths
  localparam int IDX_W   = 12;
  localparam int GRAD_W  = 32;
  localparam int UPD_W   = 32;
  localparam int LR_W    = 24;
  localparam int BETA_W  = 16;
  localparam int EPS_W   = 32;
  localparam int POW_W   = 33;
  localparam int MOM1_W  = 32;
  localparam int MOM2_W  = 48;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STABILITY_TERM = 8'd3;

  // register reset values
  localparam logic [LR_W-1:0]   LR_RESET    = 24'd16777;
  localparam logic [BETA_W-1:0] BETA1_RESET = 16'd58982;
  localparam logic [BETA_W-1:0] BETA2_RESET = 16'd65470;
  localparam logic [EPS_W-1:0]  EPS_RESET   = 32'd43;
  localparam logic [POW_W-1:0]  ONE_Q32     = 33'h1_0000_0000;

  // iterative unit geometry
  localparam int REM_W   = 43;
  localparam int LOW_W   = 64;
  localparam int DEN_W   = 41;
  localparam int QUO_W   = 49;
  localparam int STEP_W  = 7;
  localparam logic [STEP_W-1:0] STEPS_SCALE = 7'd49;
  localparam logic [STEP_W-1:0] STEPS_ROOT  = 7'd32;
  localparam logic [STEP_W-1:0] STEPS_QUOT  = 7'd32;

  // request to the shared divide / root unit
  typedef struct packed {
    logic              start;
    logic              root;
    logic [STEP_W-1:0] steps;
  } iter_req_t;

endpackage

`default_nettype wire

/* hdl/adu_if.sv */
// ----------------------------------------------------------------------------
// adu_if
// Channel interfaces of the Adam update block: input, result, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface adu_in_if;
  logic                            valid;
  logic                            ready;
  logic [adu_pkg::IDX_W-1:0]       element_index;
  logic signed [adu_pkg::GRAD_W-1:0] gradient;
  logic                            step_start;
  modport source (output valid, element_index, gradient, step_start, input ready);
  modport sink   (input valid, element_index, gradient, step_start, output ready);
endinterface

interface adu_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [adu_pkg::UPD_W-1:0] update_value;
  logic [adu_pkg::IDX_W-1:0]        result_index;
  logic                             saturated;
  modport source (output valid, update_value, result_index, saturated, input ready);
  modport sink   (input valid, update_value, result_index, saturated, output ready);
endinterface

interface adu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [adu_pkg::CFG_IDX_W-1:0]     index;
  logic [adu_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/adu_ram.sv */
// ----------------------------------------------------------------------------
// adu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module adu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/adu_iter.sv */
// ----------------------------------------------------------------------------
// adu_iter
// Shared restoring divide / square root unit, one quotient or root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module adu_iter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire adu_pkg::iter_req_t        req,
  input  wire logic [adu_pkg::REM_W-1:0] rem_init,
  input  wire logic [adu_pkg::LOW_W-1:0] low_init,
  input  wire logic [adu_pkg::DEN_W-1:0] den_init,
  output logic                           busy,
  output logic [adu_pkg::QUO_W-1:0]      quo
);

  logic [adu_pkg::REM_W-1:0]  rem;
  logic [adu_pkg::LOW_W-1:0]  low;
  logic [adu_pkg::DEN_W-1:0]  den;
  logic [adu_pkg::STEP_W-1:0] cnt;
  logic                       root;
  logic [adu_pkg::REM_W+1:0]  trial;
  logic [adu_pkg::REM_W+1:0]  opnd;
  logic                       ge;
  logic [adu_pkg::REM_W+1:0]  diff;

  // shared compare and subtract: root takes two bits, divide one
  always_comb begin
    if (root) begin
      trial = {rem, low[adu_pkg::LOW_W-1 -: 2]};
      opnd  = {quo[adu_pkg::REM_W-1:0], 2'b01};
    end else begin
      trial = {1'b0, rem, low[adu_pkg::LOW_W-1]};
      opnd  = {4'b0, den};
    end
    ge   = trial >= opnd;
    diff = trial - opnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
      root <= req.root;
      rem  <= rem_init;
      low  <= low_init;
      den  <= den_init;
      quo  <= '0;
    end else if (busy) begin
      rem <= ge ? diff[adu_pkg::REM_W-1:0] : trial[adu_pkg::REM_W-1:0];
      quo <= {quo[adu_pkg::QUO_W-2:0], ge};
      low <= root ? {low[adu_pkg::LOW_W-3:0], 2'b00} : {low[adu_pkg::LOW_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == adu_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/adam_optimizer_update_top.sv */
// ----------------------------------------------------------------------------
// adam_optimizer_update_top
// Adam update per parameter element: moments, bias correction, scaled step.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    element_index, gradient, step_start
//  out_ch   out  valid/ready    update_value, result_index, saturated
//  cfg      in   valid/ready    index, data (ready always high)
//
//  each element passes, before the next transfer is taken, through ten
//  steps on the shared 33x33 multiplier, a root and, unless skipped or
//  clipped at once, two bias divides and a final divide on the shared
//  divide / root unit, one bit a cycle.
//  after reset the moment stores are cleared, one entry a cycle, all 4096
//  entries; no input transfer is taken meanwhile, config writes are.
//  a result held in the output register stalls only the final load.
`default_nettype none

module adam_optimizer_update_top (
  input  wire logic clk,
  input  wire logic rst,
  adu_in_if.sink    in_ch,
  adu_out_if.source out_ch,
  adu_cfg_if.sink   cfg
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_CLR  = 5'd0;
  localparam logic [ST_W-1:0] ST_IDLE = 5'd1;
  localparam logic [ST_W-1:0] ST_P1   = 5'd2;
  localparam logic [ST_W-1:0] ST_P2   = 5'd3;
  localparam logic [ST_W-1:0] ST_M1   = 5'd4;
  localparam logic [ST_W-1:0] ST_M2   = 5'd5;
  localparam logic [ST_W-1:0] ST_M3   = 5'd6;
  localparam logic [ST_W-1:0] ST_V1   = 5'd7;
  localparam logic [ST_W-1:0] ST_V2   = 5'd8;
  localparam logic [ST_W-1:0] ST_V3   = 5'd9;
  localparam logic [ST_W-1:0] ST_V4   = 5'd10;
  localparam logic [ST_W-1:0] ST_V5   = 5'd11;
  localparam logic [ST_W-1:0] ST_D1   = 5'd12;
  localparam logic [ST_W-1:0] ST_D1W  = 5'd13;
  localparam logic [ST_W-1:0] ST_D2   = 5'd14;
  localparam logic [ST_W-1:0] ST_D2W  = 5'd15;
  localparam logic [ST_W-1:0] ST_SQ   = 5'd16;
  localparam logic [ST_W-1:0] ST_SQW  = 5'd17;
  localparam logic [ST_W-1:0] ST_DEN  = 5'd18;
  localparam logic [ST_W-1:0] ST_AM   = 5'd19;
  localparam logic [ST_W-1:0] ST_QW   = 5'd20;
  localparam logic [ST_W-1:0] ST_OUT  = 5'd21;

  localparam int AW = adu_pkg::ADDR_W;

  // configuration registers
  logic [adu_pkg::LR_W-1:0]   alpha;
  logic [adu_pkg::BETA_W-1:0] beta1;
  logic [adu_pkg::BETA_W-1:0] beta2;
  logic [adu_pkg::EPS_W-1:0]  eps;

  // sequencer and datapath registers
  logic [ST_W-1:0]               state;
  logic [AW-1:0]                 clr_cnt;
  logic [adu_pkg::POW_W-1:0]     p1;
  logic [adu_pkg::POW_W-1:0]     p2;
  logic [adu_pkg::IDX_W-1:0]     idx_reg;
  logic [adu_pkg::GRAD_W-1:0]    g_reg;
  logic                          step_reg;
  logic [65:0]                   prod;
  logic [65:0]                   acc;
  logic [46:0]                   gsq;
  logic [adu_pkg::MOM2_W-1:0]    v_reg;
  logic                          mneg;
  logic [31:0]                   mmag;
  logic [31:0]                   mhat;
  logic [adu_pkg::MOM2_W-1:0]    vhat;
  logic [adu_pkg::DEN_W-1:0]     d_reg;
  logic [31:0]                   q_reg;
  logic                          clip;
  logic                          dzero;
  logic                          out_valid;
  logic [adu_pkg::UPD_W-1:0]     out_value;
  logic [adu_pkg::IDX_W-1:0]     out_index;
  logic                          out_sat;

  // combinational helpers
  logic [32:0]                   mul_a;
  logic [32:0]                   mul_b;
  logic [adu_pkg::MOM1_W-1:0]    rd_m;
  logic [adu_pkg::MOM2_W-1:0]    rd_v;
  logic [adu_pkg::MOM1_W-1:0]    m_new;
  logic [31:0]                   m_mag;
  logic [65:0]                   m_sum;
  logic [65:0]                   gsq_sum;
  logic [65:0]                   v_sum;
  logic [31:0]                   gu;
  logic [31:0]                   gmag;
  logic [16:0]                   w1;
  logic [16:0]                   w2;
  logic [adu_pkg::POW_W-1:0]     c1;
  logic [adu_pkg::POW_W-1:0]     c2;
  logic [adu_pkg::QUO_W-1:0]     lim_m;
  logic [31:0]                   lim_q;
  logic [63:0]                   numer;
  logic [40:0]                   d_next;
  logic                          m_we;
  logic                          v_we;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;
  logic                          in_fire;
  logic                          out_load;

  adu_pkg::iter_req_t            iter_req;
  logic [adu_pkg::REM_W-1:0]     iter_rem;
  logic [adu_pkg::LOW_W-1:0]     iter_low;
  logic [adu_pkg::DEN_W-1:0]     iter_den;
  logic                          iter_busy;
  logic [adu_pkg::QUO_W-1:0]     iter_quo;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state == ST_OUT) && (!out_valid || out_ch.ready);
  assign cfg.ready   = 1'b1;

  assign out_ch.valid        = out_valid;
  assign out_ch.update_value = out_value;
  assign out_ch.result_index = out_index;
  assign out_ch.saturated    = out_sat;

  // operand views
  assign gu    = g_reg ^ 32'h8000_0000;
  assign gmag  = g_reg[31] ? (~g_reg + 32'd1) : g_reg;
  assign w1    = 17'h1_0000 - {1'b0, beta1};
  assign w2    = 17'h1_0000 - {1'b0, beta2};
  assign c1    = adu_pkg::ONE_Q32 - p1;
  assign c2    = adu_pkg::ONE_Q32 - p2;
  assign lim_m = mneg ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
  assign lim_q = mneg ? 32'h7FFF_FFFF : 32'h8000_0000;

  // moment arithmetic
  assign m_sum   = acc + prod + 66'd32768;
  assign m_new   = m_sum[47:16] ^ 32'h8000_0000;
  assign m_mag   = m_new[31] ? (~m_new + 32'd1) : m_new;
  assign gsq_sum = prod + 66'd32768;
  assign v_sum   = acc + {prod[41:0], 24'b0} + 66'd32768;
  assign numer   = {prod[55:0], 8'b0} + {24'b0, d_reg[40:1]};
  assign d_next  = {1'b0, iter_quo[31:0], 8'b0} + {9'b0, eps};

  // store ports
  assign m_we  = (state == ST_CLR) || (state == ST_M3);
  assign v_we  = (state == ST_CLR) || (state == ST_V5);
  assign waddr = (state == ST_CLR) ? clr_cnt : idx_reg[AW-1:0];
  assign raddr = (state == ST_IDLE) ? in_ch.element_index[AW-1:0] : idx_reg[AW-1:0];

  adu_ram #(.WIDTH(adu_pkg::MOM1_W), .DEPTH(adu_pkg::NUM_ELEMENTS)) u_first (
    .clk   (clk),
    .we    (m_we),
    .waddr (waddr),
    .wdata ((state == ST_CLR) ? '0 : m_new),
    .raddr (raddr),
    .rdata (rd_m)
  );

  adu_ram #(.WIDTH(adu_pkg::MOM2_W), .DEPTH(adu_pkg::NUM_ELEMENTS)) u_second (
    .clk   (clk),
    .we    (v_we),
    .waddr (waddr),
    .wdata ((state == ST_CLR) ? '0 : v_sum[63:16]),
    .raddr (raddr),
    .rdata (rd_v)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_P1: begin mul_a = p1; mul_b = {17'b0, beta1}; end
      ST_P2: begin mul_a = p2; mul_b = {17'b0, beta2}; end
      ST_M1: begin mul_a = {1'b0, rd_m ^ 32'h8000_0000}; mul_b = {17'b0, beta1}; end
      ST_M2: begin mul_a = {1'b0, gu}; mul_b = {16'b0, w1}; end
      ST_M3: begin mul_a = {1'b0, gmag}; mul_b = {1'b0, gmag}; end
      ST_V1: begin mul_a = {17'b0, beta2}; mul_b = {9'b0, rd_v[23:0]}; end
      ST_V2: begin mul_a = {17'b0, beta2}; mul_b = {9'b0, rd_v[47:24]}; end
      ST_V3: begin mul_a = {16'b0, w2}; mul_b = {9'b0, gsq[23:0]}; end
      ST_V4: begin mul_a = {16'b0, w2}; mul_b = {10'b0, gsq[46:24]}; end
      ST_DEN: begin mul_a = {9'b0, alpha}; mul_b = {1'b0, mhat}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divide / root requests
  always_comb begin
    iter_req = '0;
    iter_rem = '0;
    iter_low = '0;
    iter_den = '0;
    case (state)
      ST_D1: begin
        iter_req.start = (c1 != '0) && ({18'b0, mmag} < {c1, 17'b0});
        iter_req.steps = adu_pkg::STEPS_SCALE;
        iter_rem       = {28'b0, mmag[31:17]};
        iter_low       = {mmag[16:0], 47'b0};
        iter_den       = {8'b0, c1};
      end
      ST_D2: begin
        iter_req.start = (c2 != '0) && ({2'b0, v_reg} < {c2, 17'b0});
        iter_req.steps = adu_pkg::STEPS_SCALE;
        iter_rem       = {12'b0, v_reg[47:17]};
        iter_low       = {v_reg[16:0], 47'b0};
        iter_den       = {8'b0, c2};
      end
      ST_SQ: begin
        iter_req.start = 1'b1;
        iter_req.root  = 1'b1;
        iter_req.steps = adu_pkg::STEPS_ROOT;
        iter_low       = {vhat, 16'b0};
      end
      ST_AM: begin
        iter_req.start = {9'b0, numer} < {d_reg, 32'b0};
        iter_req.steps = adu_pkg::STEPS_QUOT;
        iter_rem       = {11'b0, numer[63:32]};
        iter_low       = {numer[31:0], 32'b0};
        iter_den       = d_reg;
      end
      default: begin
        iter_req = '0;
      end
    endcase
  end

  adu_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .req      (iter_req),
    .rem_init (iter_rem),
    .low_init (iter_low),
    .den_init (iter_den),
    .busy     (iter_busy),
    .quo      (iter_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= adu_pkg::LR_RESET;
      beta1 <= adu_pkg::BETA1_RESET;
      beta2 <= adu_pkg::BETA2_RESET;
      eps   <= adu_pkg::EPS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        adu_pkg::CFG_LEARNING_RATE:  alpha <= cfg.data[adu_pkg::LR_W-1:0];
        adu_pkg::CFG_FIRST_DECAY:    beta1 <= cfg.data[adu_pkg::BETA_W-1:0];
        adu_pkg::CFG_SECOND_DECAY:   beta2 <= cfg.data[adu_pkg::BETA_W-1:0];
        adu_pkg::CFG_STABILITY_TERM: eps   <= cfg.data[adu_pkg::EPS_W-1:0];
        default: begin end
      endcase
    end
  end

  // multiplier product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      p1        <= adu_pkg::ONE_Q32;
      p2        <= adu_pkg::ONE_Q32;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(adu_pkg::NUM_ELEMENTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            idx_reg  <= in_ch.element_index;
            g_reg    <= in_ch.gradient;
            step_reg <= in_ch.step_start;
            clip     <= 1'b0;
            dzero    <= 1'b0;
            state    <= ST_P1;
          end
        end
        ST_P1: state <= ST_P2;
        ST_P2: begin
          if (step_reg) begin
            p1 <= gsq_sum[48:16];
          end
          state <= ST_M1;
        end
        ST_M1: begin
          if (step_reg) begin
            p2 <= gsq_sum[48:16];
          end
          state <= ST_M2;
        end
        ST_M2: begin
          acc   <= prod;
          state <= ST_M3;
        end
        ST_M3: begin
          mneg  <= m_new[31];
          mmag  <= m_mag;
          state <= ST_V1;
        end
        ST_V1: begin
          gsq   <= gsq_sum[62:16];
          state <= ST_V2;
        end
        ST_V2: begin
          acc   <= prod;
          state <= ST_V3;
        end
        ST_V3: begin
          acc   <= acc + {prod[41:0], 24'b0};
          state <= ST_V4;
        end
        ST_V4: begin
          acc   <= acc + prod;
          state <= ST_V5;
        end
        ST_V5: begin
          v_reg <= v_sum[63:16];
          state <= ST_D1;
        end
        // first moment correction
        ST_D1: begin
          if (c1 == '0) begin
            mhat  <= mmag;
            state <= ST_D2;
          end else if (iter_req.start) begin
            state <= ST_D1W;
          end else begin
            mhat  <= lim_m[31:0];
            clip  <= 1'b1;
            state <= ST_D2;
          end
        end
        ST_D1W: begin
          if (!iter_busy) begin
            if (iter_quo > lim_m) begin
              mhat <= lim_m[31:0];
              clip <= 1'b1;
            end else begin
              mhat <= iter_quo[31:0];
            end
            state <= ST_D2;
          end
        end
        // second moment correction
        ST_D2: begin
          if (c2 == '0) begin
            vhat  <= v_reg;
            state <= ST_SQ;
          end else if (iter_req.start) begin
            state <= ST_D2W;
          end else begin
            vhat  <= '1;
            clip  <= 1'b1;
            state <= ST_SQ;
          end
        end
        ST_D2W: begin
          if (!iter_busy) begin
            if (iter_quo > {1'b0, {adu_pkg::MOM2_W{1'b1}}}) begin
              vhat <= '1;
              clip <= 1'b1;
            end else begin
              vhat <= iter_quo[adu_pkg::MOM2_W-1:0];
            end
            state <= ST_SQ;
          end
        end
        ST_SQ: state <= ST_SQW;
        ST_SQW: begin
          if (!iter_busy) begin
            d_reg <= d_next;
            state <= ST_DEN;
          end
        end
        ST_DEN: begin
          if (d_reg == '0) begin
            dzero <= 1'b1;
            state <= ST_OUT;
          end else begin
            state <= ST_AM;
          end
        end
        ST_AM: begin
          if (iter_req.start) begin
            state <= ST_QW;
          end else begin
            q_reg <= lim_q;
            clip  <= 1'b1;
            state <= ST_OUT;
          end
        end
        ST_QW: begin
          if (!iter_busy) begin
            if (iter_quo > {17'b0, lim_q}) begin
              q_reg <= lim_q;
              clip  <= 1'b1;
            end else begin
              q_reg <= iter_quo[31:0];
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_index <= idx_reg;
            out_sat   <= clip || dzero;
            if (dzero) begin
              out_value <= '0;
            end else begin
              out_value <= mneg ? q_reg : (32'd0 - q_reg);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    iter_req.start |-> !iter_busy)
    else $error("divide/root unit started while busy");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_P1) && !in_ch.ready)
    else $error("transfer did not start the sequence");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    (p1 <= adu_pkg::ONE_Q32) && (p2 <= adu_pkg::ONE_Q32))
    else $error("decay power above one");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == ST_IDLE))
    else $error("result load lost");

endmodule

`default_nettype wire
